// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/tcg_pkg.sv =====
package tcg_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int AREA_W  = 33;
    localparam int OUT_W   = 32;
    // Divider operand magnitudes: numerator stays below 2^48, 2*D below 2^35
    localparam int NUM_W   = 50;
    localparam int DEN_W   = 36;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = RAD_W / 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } in_item_t;

    typedef struct packed {
        logic        [AREA_W-1:0] area;
        logic signed [OUT_W-1:0]  center_x;
        logic signed [OUT_W-1:0]  center_y;
        logic        [OUT_W-1:0]  radius;
        logic                     inside_res;
        logic                     degenerate;
        logic                     saturated;
    } out_item_t;

    // Sideband riding along the center divider
    typedef struct packed {
        logic        [AREA_W-1:0]  area;
        logic                      in_tri;
        logic                      degen;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic                      negx;
    } div_tag_t;

    // Sideband riding along the square root
    typedef struct packed {
        logic        [AREA_W-1:0] area;
        logic                     in_tri;
        logic                     degen;
        logic signed [OUT_W-1:0]  ox;
        logic signed [OUT_W-1:0]  oy;
        logic                     csat;
        logic                     rsat;
    } root_tag_t;

endpackage

// ===== rtl/tcg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
module tcg_div #(
    parameter int N     = tcg_pkg::NUM_W,
    parameter int M     = tcg_pkg::DEN_W,
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [N-1:0]     in_num,
    input  logic [M-1:0]     in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [N-1:0]     out_quo,
    output logic [TAG_W-1:0] out_tag
);

    logic             vld_reg  [N];
    logic [M:0]       rem_reg  [N];
    logic [N-1:0]     work_reg [N];
    logic [M-1:0]     den_reg  [N];
    logic [TAG_W-1:0] tag_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic             vld_in;
        logic [TAG_W-1:0] tag_in;
        logic [M:0]   rem_in;
        logic [N-1:0] work_in;
        logic [M-1:0] den_in;
        logic [M:0]   shifted;
        logic [M+1:0] diff;
        logic [M:0]   rem_next;
        logic [N-1:0] work_next;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign tag_in  = in_tag;
            assign rem_in  = '0;
            assign work_in = in_num;
            assign den_in  = in_den;
        end else begin : g_mid
            assign vld_in  = vld_reg[k-1];
            assign tag_in  = tag_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign work_in = work_reg[k-1];
            assign den_in  = den_reg[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        always_comb begin
            shifted = {rem_in[M-1:0], work_in[N-1]};
            diff    = {1'b0, shifted} - {2'b00, den_in};
            if (!diff[M+1]) begin
                rem_next  = diff[M:0];
                work_next = {work_in[N-2:0], 1'b1};
            end else begin
                rem_next  = shifted;
                work_next = {work_in[N-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                work_reg[k] <= work_next;
                den_reg[k]  <= den_in;
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_quo   = work_reg[N-1];
    assign out_tag   = tag_reg[N-1];

endmodule

// ===== rtl/tcg_isqrt.sv =====
// Pipelined floor square root, two radicand bits per stage.
module tcg_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [tcg_pkg::RAD_W-1:0]  in_rad,
    input  logic [TAG_W-1:0]           in_tag,
    output logic                       out_valid,
    output logic [tcg_pkg::ROOT_W-1:0] out_root,
    output logic [TAG_W-1:0]           out_tag
);
    import tcg_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic              vld_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  work_reg [ROOT_W];
    logic [TAG_W-1:0]  tag_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              vld_in;
        logic [TAG_W-1:0]  tag_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  work_in;
        logic [REM_W+1:0]  shifted;
        logic [REM_W+1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign tag_in  = in_tag;
            assign rem_in  = '0;
            assign root_in = '0;
            assign work_in = in_rad;
        end else begin : g_mid
            assign vld_in  = vld_reg[k-1];
            assign tag_in  = tag_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign work_in = work_reg[k-1];
        end

        // bring down two bits, try root*4+1
        always_comb begin
            shifted = {rem_in, work_in[RAD_W-1 -: 2]};
            trial   = {2'b00, root_in, 2'b01};
            if (shifted >= trial) begin
                rem_next  = REM_W'(shifted - trial);
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = REM_W'(shifted);
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                work_reg[k] <= {work_in[RAD_W-3:0], 2'b00};
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

// ===== rtl/triangle_circumcircle_geometry.sv =====
// Stages from input beat to result beat: 5 front stages, 50-stage center divider,
// 5 stages for distance, 32-stage square root, output register.
// Throughput: one beat per cycle; the pipeline stalls as a whole only when both
// the output register and the skid register hold a result.
// Reset: aresetn is synchronous, active low, and clears all valid bits.
`include "assert_macros.svh"

module triangle_circumcircle_geometry (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcg_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output tcg_pkg::out_item_t  m_item
);
    import tcg_pkg::*;

    localparam int PROD_W = 2 * DIFF_W;      // edge products
    localparam int CRS_W  = PROD_W + 1;      // cross products
    localparam int SQ_W   = 2 * COORD_W;     // coordinate squares
    localparam int REL_W  = SQ_W + 2;        // b2, c2
    localparam int NP_W   = DIFF_W + REL_W;  // numerator partial products
    localparam int NUM_S  = NP_W + 1;        // numerator sums
    localparam int UX_W   = NUM_W + 1;       // signed center
    localparam int DX_W   = UX_W + 1;        // center minus vertex A

    logic en;
    logic skid_valid_reg;
    out_item_t skid_item_reg;
    logic m_valid_reg;
    out_item_t m_item_reg;

    // whole pipeline moves while the skid register is free
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // ---------------- stage A: edge differences and products
    logic signed [DIFF_W-1:0] bax, bay, cax, cay, pbx, pby, cbx, cby;
    logic signed [DIFF_W-1:0] pcx, pcy, acx, acy, pax, pay, aby;
    logic va_reg;
    logic signed [PROD_W-1:0] pd1_reg, pd2_reg, pe1a_reg, pe1b_reg;
    logic signed [PROD_W-1:0] pe2a_reg, pe2b_reg, pe3a_reg, pe3b_reg;
    logic signed [SQ_W-1:0]   sqax_reg, sqay_reg, sqbx_reg, sqby_reg, sqcx_reg, sqcy_reg;
    logic signed [DIFF_W-1:0] cay_a_reg, aby_a_reg, acx_a_reg, bax_a_reg;
    logic signed [COORD_W-1:0] ax_a_reg, ay_a_reg;

    always_comb begin
        bax = DIFF_W'(s_item.bx) - DIFF_W'(s_item.ax);
        bay = DIFF_W'(s_item.by_coord) - DIFF_W'(s_item.ay);
        cax = DIFF_W'(s_item.cx) - DIFF_W'(s_item.ax);
        cay = DIFF_W'(s_item.cy) - DIFF_W'(s_item.ay);
        pbx = DIFF_W'(s_item.px) - DIFF_W'(s_item.bx);
        pby = DIFF_W'(s_item.py) - DIFF_W'(s_item.by_coord);
        cbx = DIFF_W'(s_item.cx) - DIFF_W'(s_item.bx);
        cby = DIFF_W'(s_item.cy) - DIFF_W'(s_item.by_coord);
        pcx = DIFF_W'(s_item.px) - DIFF_W'(s_item.cx);
        pcy = DIFF_W'(s_item.py) - DIFF_W'(s_item.cy);
        acx = DIFF_W'(s_item.ax) - DIFF_W'(s_item.cx);
        acy = DIFF_W'(s_item.ay) - DIFF_W'(s_item.cy);
        pax = DIFF_W'(s_item.px) - DIFF_W'(s_item.ax);
        pay = DIFF_W'(s_item.py) - DIFF_W'(s_item.ay);
        aby = DIFF_W'(s_item.ay) - DIFF_W'(s_item.by_coord);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_valid;
        end
        if (en) begin
            pd1_reg   <= bax * cay;
            pd2_reg   <= bay * cax;
            pe1a_reg  <= bax * pby;
            pe1b_reg  <= bay * pbx;
            pe2a_reg  <= cbx * pcy;
            pe2b_reg  <= cby * pcx;
            pe3a_reg  <= acx * pay;
            pe3b_reg  <= acy * pax;
            sqax_reg  <= s_item.ax * s_item.ax;
            sqay_reg  <= s_item.ay * s_item.ay;
            sqbx_reg  <= s_item.bx * s_item.bx;
            sqby_reg  <= s_item.by_coord * s_item.by_coord;
            sqcx_reg  <= s_item.cx * s_item.cx;
            sqcy_reg  <= s_item.cy * s_item.cy;
            cay_a_reg <= cay;
            aby_a_reg <= aby;
            acx_a_reg <= acx;
            bax_a_reg <= bax;
            ax_a_reg  <= s_item.ax;
            ay_a_reg  <= s_item.ay;
        end
    end

    // ---------------- stage B: cross products and squared norms
    logic signed [CRS_W-1:0] d_next, e1_next, e2_next, e3_next;
    logic signed [REL_W-1:0] a2_next, b2_next, c2_next;
    logic vb_reg;
    logic signed [CRS_W-1:0] d_reg, e1_reg, e2_reg, e3_reg;
    logic signed [REL_W-1:0] b2_reg, c2_reg;
    logic signed [DIFF_W-1:0] cay_b_reg, aby_b_reg, acx_b_reg, bax_b_reg;
    logic signed [COORD_W-1:0] ax_b_reg, ay_b_reg;

    always_comb begin
        d_next  = CRS_W'(pd1_reg) - CRS_W'(pd2_reg);
        e1_next = CRS_W'(pe1a_reg) - CRS_W'(pe1b_reg);
        e2_next = CRS_W'(pe2a_reg) - CRS_W'(pe2b_reg);
        e3_next = CRS_W'(pe3a_reg) - CRS_W'(pe3b_reg);
        a2_next = REL_W'(sqax_reg) + REL_W'(sqay_reg);
        b2_next = REL_W'(sqbx_reg) + REL_W'(sqby_reg) - a2_next;
        c2_next = REL_W'(sqcx_reg) + REL_W'(sqcy_reg) - a2_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
        if (en) begin
            d_reg     <= d_next;
            e1_reg    <= e1_next;
            e2_reg    <= e2_next;
            e3_reg    <= e3_next;
            b2_reg    <= b2_next;
            c2_reg    <= c2_next;
            cay_b_reg <= cay_a_reg;
            aby_b_reg <= aby_a_reg;
            acx_b_reg <= acx_a_reg;
            bax_b_reg <= bax_a_reg;
            ax_b_reg  <= ax_a_reg;
            ay_b_reg  <= ay_a_reg;
        end
    end

    // ---------------- stage C: numerator products, area, point test
    logic [AREA_W-1:0] area_next;
    logic inside_next, pos1, pos2, pos3;
    logic vc_reg;
    logic signed [NP_W-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [DEN_W-1:0] den_c_reg;
    logic [AREA_W-1:0] area_c_reg;
    logic inside_c_reg, degen_c_reg;
    logic signed [COORD_W-1:0] ax_c_reg, ay_c_reg;

    always_comb begin
        area_next   = d_reg[CRS_W-1] ? AREA_W'(-d_reg) : AREA_W'(d_reg);
        pos1        = !e1_reg[CRS_W-1] && (e1_reg != '0);
        pos2        = !e2_reg[CRS_W-1] && (e2_reg != '0);
        pos3        = !e3_reg[CRS_W-1] && (e3_reg != '0);
        inside_next = (pos1 && pos2 && pos3) ||
                      (e1_reg[CRS_W-1] && e2_reg[CRS_W-1] && e3_reg[CRS_W-1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (en) begin
            vc_reg <= vb_reg;
        end
        if (en) begin
            m1_reg       <= cay_b_reg * b2_reg;
            m2_reg       <= aby_b_reg * c2_reg;
            m3_reg       <= acx_b_reg * b2_reg;
            m4_reg       <= bax_b_reg * c2_reg;
            den_c_reg    <= {d_reg, 1'b0};
            area_c_reg   <= area_next;
            inside_c_reg <= inside_next;
            degen_c_reg  <= (d_reg == '0);
            ax_c_reg     <= ax_b_reg;
            ay_c_reg     <= ay_b_reg;
        end
    end

    // ---------------- stage D: numerator sums
    logic vd_reg;
    logic signed [NUM_S-1:0] nx_reg, ny_reg;
    logic signed [DEN_W-1:0] den_d_reg;
    logic [AREA_W-1:0] area_d_reg;
    logic inside_d_reg, degen_d_reg;
    logic signed [COORD_W-1:0] ax_d_reg, ay_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= vc_reg;
        end
        if (en) begin
            nx_reg       <= NUM_S'(m1_reg) + NUM_S'(m2_reg);
            ny_reg       <= NUM_S'(m3_reg) + NUM_S'(m4_reg);
            den_d_reg    <= den_c_reg;
            area_d_reg   <= area_c_reg;
            inside_d_reg <= inside_c_reg;
            degen_d_reg  <= degen_c_reg;
            ax_d_reg     <= ax_c_reg;
            ay_d_reg     <= ay_c_reg;
        end
    end

    // ---------------- stage E: magnitudes and quotient signs
    logic ve_reg;
    logic [NUM_W-1:0] nxm_reg, nym_reg;
    logic [DEN_W-1:0] denm_reg;
    div_tag_t tag_e_reg;
    logic negy_e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
        end else if (en) begin
            ve_reg <= vd_reg;
        end
        if (en) begin
            nxm_reg  <= nx_reg[NUM_S-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
            nym_reg  <= ny_reg[NUM_S-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
            denm_reg <= den_d_reg[DEN_W-1] ? DEN_W'(-den_d_reg) : DEN_W'(den_d_reg);
            tag_e_reg.area   <= area_d_reg;
            tag_e_reg.in_tri <= inside_d_reg;
            tag_e_reg.degen  <= degen_d_reg;
            tag_e_reg.ax     <= ax_d_reg;
            tag_e_reg.ay     <= ay_d_reg;
            tag_e_reg.negx   <= nx_reg[NUM_S-1] ^ den_d_reg[DEN_W-1];
            negy_e_reg       <= ny_reg[NUM_S-1] ^ den_d_reg[DEN_W-1];
        end
    end

    // ---------------- center dividers
    logic qx_valid, qy_valid;
    logic [NUM_W-1:0] qx, qy;
    div_tag_t qx_tag;
    logic qy_neg;

    tcg_div #(.N(NUM_W), .M(DEN_W), .TAG_W($bits(div_tag_t))) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ve_reg),
        .in_num    (nxm_reg),
        .in_den    (denm_reg),
        .in_tag    (tag_e_reg),
        .out_valid (qx_valid),
        .out_quo   (qx),
        .out_tag   (qx_tag)
    );

    tcg_div #(.N(NUM_W), .M(DEN_W), .TAG_W(1)) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ve_reg),
        .in_num    (nym_reg),
        .in_den    (denm_reg),
        .in_tag    (negy_e_reg),
        .out_valid (qy_valid),
        .out_quo   (qy),
        .out_tag   (qy_neg)
    );

    // ---------------- stage F: signed center
    logic vf_reg;
    logic signed [UX_W-1:0] ux_reg, uy_reg;
    div_tag_t tag_f_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (en) begin
            vf_reg <= qx_valid;
        end
        if (en) begin
            ux_reg    <= qx_tag.negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            uy_reg    <= qy_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            tag_f_reg <= qx_tag;
        end
    end

    // ---------------- stage G: offset from vertex A, clamp center
    localparam logic signed [UX_W-1:0] CMAX = UX_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [UX_W-1:0] CMIN = -CMAX - UX_W'(1);

    logic signed [OUT_W-1:0] ox_next, oy_next;
    logic csat_next;
    logic vg_reg;
    logic signed [DX_W-1:0] dxs_reg, dys_reg;
    logic signed [OUT_W-1:0] ox_g_reg, oy_g_reg;
    logic csat_g_reg;
    logic [AREA_W-1:0] area_g_reg;
    logic inside_g_reg, degen_g_reg;

    always_comb begin
        csat_next = 1'b0;
        if (ux_reg > CMAX) begin
            ox_next   = CMAX[OUT_W-1:0];
            csat_next = 1'b1;
        end else if (ux_reg < CMIN) begin
            ox_next   = CMIN[OUT_W-1:0];
            csat_next = 1'b1;
        end else begin
            ox_next   = ux_reg[OUT_W-1:0];
        end
        if (uy_reg > CMAX) begin
            oy_next   = CMAX[OUT_W-1:0];
            csat_next = 1'b1;
        end else if (uy_reg < CMIN) begin
            oy_next   = CMIN[OUT_W-1:0];
            csat_next = 1'b1;
        end else begin
            oy_next   = uy_reg[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg_reg <= 1'b0;
        end else if (en) begin
            vg_reg <= vf_reg;
        end
        if (en) begin
            dxs_reg      <= DX_W'(ux_reg) - DX_W'(tag_f_reg.ax);
            dys_reg      <= DX_W'(uy_reg) - DX_W'(tag_f_reg.ay);
            ox_g_reg     <= ox_next;
            oy_g_reg     <= oy_next;
            csat_g_reg   <= csat_next;
            area_g_reg   <= tag_f_reg.area;
            inside_g_reg <= tag_f_reg.in_tri;
            degen_g_reg  <= tag_f_reg.degen;
        end
    end

    // ---------------- stage H: absolute offsets, range check
    logic [DX_W-1:0] adx_next, ady_next;
    logic vh_reg;
    logic [OUT_W-1:0] adx_reg, ady_reg;
    logic big_h_reg;
    root_tag_t tag_h_reg;

    always_comb begin
        adx_next = dxs_reg[DX_W-1] ? DX_W'(-dxs_reg) : DX_W'(dxs_reg);
        ady_next = dys_reg[DX_W-1] ? DX_W'(-dys_reg) : DX_W'(dys_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vh_reg <= 1'b0;
        end else if (en) begin
            vh_reg <= vg_reg;
        end
        if (en) begin
            adx_reg          <= adx_next[OUT_W-1:0];
            ady_reg          <= ady_next[OUT_W-1:0];
            big_h_reg        <= (adx_next[DX_W-1:OUT_W] != '0) ||
                                (ady_next[DX_W-1:OUT_W] != '0);
            tag_h_reg.area   <= area_g_reg;
            tag_h_reg.in_tri <= inside_g_reg;
            tag_h_reg.degen  <= degen_g_reg;
            tag_h_reg.ox     <= ox_g_reg;
            tag_h_reg.oy     <= oy_g_reg;
            tag_h_reg.csat   <= csat_g_reg;
            tag_h_reg.rsat   <= 1'b0;
        end
    end

    // ---------------- stage I: squares
    logic vi_reg;
    logic [RAD_W-1:0] sx2_reg, sy2_reg;
    logic big_i_reg;
    root_tag_t tag_i_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vi_reg <= 1'b0;
        end else if (en) begin
            vi_reg <= vh_reg;
        end
        if (en) begin
            sx2_reg   <= adx_reg * adx_reg;
            sy2_reg   <= ady_reg * ady_reg;
            big_i_reg <= big_h_reg;
            tag_i_reg <= tag_h_reg;
        end
    end

    // ---------------- stage J: squared radius, overflow check
    logic [RAD_W:0] sum_next;
    root_tag_t tag_j_next;
    logic vj_reg;
    logic [RAD_W-1:0] rad2_reg;
    root_tag_t tag_j_reg;

    assign sum_next = {1'b0, sx2_reg} + {1'b0, sy2_reg};

    always_comb begin
        tag_j_next      = tag_i_reg;
        tag_j_next.rsat = big_i_reg || sum_next[RAD_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vj_reg <= 1'b0;
        end else if (en) begin
            vj_reg <= vi_reg;
        end
        if (en) begin
            rad2_reg  <= sum_next[RAD_W-1:0];
            tag_j_reg <= tag_j_next;
        end
    end

    // ---------------- square root
    logic r_valid;
    logic [ROOT_W-1:0] r_root;
    root_tag_t r_tag;

    tcg_isqrt #(.TAG_W($bits(root_tag_t))) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vj_reg),
        .in_rad    (rad2_reg),
        .in_tag    (tag_j_reg),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_tag   (r_tag)
    );

    // ---------------- result assembly
    out_item_t res_next;

    always_comb begin
        res_next.area       = r_tag.area;
        res_next.inside_res = r_tag.in_tri;
        res_next.degenerate = r_tag.degen;
        if (r_tag.degen) begin
            res_next.center_x  = '0;
            res_next.center_y  = '0;
            res_next.radius    = '0;
            res_next.saturated = 1'b0;
        end else begin
            res_next.center_x  = r_tag.ox;
            res_next.center_y  = r_tag.oy;
            res_next.radius    = r_tag.rsat ? '1 : r_root;
            res_next.saturated = r_tag.csat || r_tag.rsat;
        end
    end

    // ---------------- output register with skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= r_valid;
        end else if (r_valid) begin
            skid_valid_reg <= 1'b1;
        end
        if (skid_valid_reg) begin
            if (m_ready) begin
                m_item_reg <= skid_item_reg;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_item_reg <= res_next;
        end else begin
            skid_item_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ---------------- checks
    `ASSERT_IMPLIES(a_skid_needs_out, aclk, aresetn, skid_valid_reg, m_valid_reg)
    `ASSERT_IMPLIES(a_degen_zero, aclk, aresetn, m_valid_reg && m_item_reg.degenerate,
        m_item_reg.center_x == '0 && m_item_reg.radius == '0 && !m_item_reg.saturated)
    `ASSERT_IMPLIES(a_degen_outside, aclk, aresetn, m_valid_reg && m_item_reg.degenerate,
        !m_item_reg.inside_res && m_item_reg.area == '0)
    `ASSERT_NEXT(a_skid_drain, aclk, aresetn, skid_valid_reg && m_ready, !skid_valid_reg)
    `ASSERT_IMPLIES(a_div_lockstep, aclk, aresetn, qx_valid, qy_valid)

endmodule

// ===== sim/tcg_checker.sv =====
module tcg_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tcg_pkg::in_item_t   s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tcg_pkg::out_item_t  m_item,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcg_pkg::*;

    out_item_t geom_q[$];

    function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
        return ux * vy - uy * vx;
    endfunction

    function automatic longint absl(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Bitwise floor square root of a 64-bit value
    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic out_item_t predict_geometry(in_item_t it);
        out_item_t o;
        longint ax, ay, bx, by, cx, cy, px, py;
        longint d, e1, e2, e3, a2, b2, c2, nx, ny, den, ux, uy, dx, dy;
        logic [63:0] sum;
        ax = it.ax; ay = it.ay; bx = it.bx; by = it.by_coord;
        cx = it.cx; cy = it.cy; px = it.px; py = it.py;
        o = '0;
        d = cross2(bx - ax, by - ay, cx - ax, cy - ay);
        o.area = AREA_W'(absl(d));
        e1 = cross2(bx - ax, by - ay, px - bx, py - by);
        e2 = cross2(cx - bx, cy - by, px - cx, py - cy);
        e3 = cross2(ax - cx, ay - cy, px - ax, py - ay);
        o.inside_res = (e1 > 0 && e2 > 0 && e3 > 0) || (e1 < 0 && e2 < 0 && e3 < 0);
        o.degenerate = (d == 0);
        if (d != 0) begin
            a2 = ax * ax + ay * ay;
            b2 = bx * bx + by * by - a2;
            c2 = cx * cx + cy * cy - a2;
            nx = (cy - ay) * b2 + (ay - by) * c2;
            ny = (ax - cx) * b2 + (bx - ax) * c2;
            den = 2 * d;
            ux = nx / den;
            uy = ny / den;
            // clamp center to 32 bits
            if (ux > 64'sd2147483647) begin
                o.center_x = 32'h7fffffff; o.saturated = 1;
            end else if (ux < -64'sd2147483648) begin
                o.center_x = 32'h80000000; o.saturated = 1;
            end else o.center_x = 32'(ux);
            if (uy > 64'sd2147483647) begin
                o.center_y = 32'h7fffffff; o.saturated = 1;
            end else if (uy < -64'sd2147483648) begin
                o.center_y = 32'h80000000; o.saturated = 1;
            end else o.center_y = 32'(uy);
            // radius from unclamped center
            dx = absl(ux - ax);
            dy = absl(uy - ay);
            if (dx >= 64'sd4294967296 || dy >= 64'sd4294967296) begin
                o.radius = '1; o.saturated = 1;
            end else begin
                sum = 64'(dx * dx) + 64'(dy * dy);
                if (sum < 64'(dx * dx)) begin
                    o.radius = '1; o.saturated = 1;
                end else o.radius = 32'(floor_root(sum));
            end
        end
        return o;
    endfunction

    // Predict on input beats, compare on result beats
    always @(posedge aclk) begin
        out_item_t exp_item;
        if (!aresetn) begin
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (s_valid && s_ready) geom_q = {geom_q, predict_geometry(s_item)};
            if (m_valid && m_ready) begin
                if (geom_q.size() == 0) begin
                    $error("result beat with no expectation");
                    fail_count <= fail_count + 1;
                end else begin
                    exp_item = geom_q.pop_front();
                    if (m_item !== exp_item) begin
                        fail_count <= fail_count + 1;
                        if (m_item.area !== exp_item.area)
                            $error("area exp %0d got %0d", exp_item.area, m_item.area);
                        if (m_item.center_x !== exp_item.center_x)
                            $error("center_x exp %0d got %0d", exp_item.center_x,
                                   m_item.center_x);
                        if (m_item.center_y !== exp_item.center_y)
                            $error("center_y exp %0d got %0d", exp_item.center_y,
                                   m_item.center_y);
                        if (m_item.radius !== exp_item.radius)
                            $error("radius exp %0d got %0d", exp_item.radius, m_item.radius);
                        if (m_item.inside_res !== exp_item.inside_res)
                            $error("inside_res exp %0b got %0b", exp_item.inside_res,
                                   m_item.inside_res);
                        if (m_item.degenerate !== exp_item.degenerate)
                            $error("degenerate exp %0b got %0b", exp_item.degenerate,
                                   m_item.degenerate);
                        if (m_item.saturated !== exp_item.saturated)
                            $error("saturated exp %0b got %0b", exp_item.saturated,
                                   m_item.saturated);
                    end
                end
            end
            pending <= geom_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcg_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 930;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    int        fail_count;
    int        pending;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        idle_cycles;
    bit        timed_out;

    triangle_circumcircle_geometry u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    tcg_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Receiver stalls at random
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (aresetn && idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] rand_coord(int spread);
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(2 * spread)) - spread);
            2: return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(512)) - 256);
        endcase
    endfunction

    function automatic in_item_t mk_item(int ax, int ay, int bx, int by, int cx, int cy,
                                         int px, int py);
        in_item_t it;
        it.ax = 16'(ax); it.ay = 16'(ay); it.bx = 16'(bx); it.by_coord = 16'(by);
        it.cx = 16'(cx); it.cy = 16'(cy); it.px = 16'(px); it.py = 16'(py);
        return it;
    endfunction

    // Random triangle; some collinear, some with P on an edge or a vertex
    function automatic in_item_t rand_triangle();
        in_item_t it;
        int spread;
        int k;
        spread = 1 << $urandom_range(2, 15);
        it.ax = rand_coord(spread); it.ay = rand_coord(spread);
        it.bx = rand_coord(spread); it.by_coord = rand_coord(spread);
        it.cx = rand_coord(spread); it.cy = rand_coord(spread);
        it.px = rand_coord(spread); it.py = rand_coord(spread);
        case ($urandom_range(9))
            0: begin
                // collinear: C = A + k(B-A)
                k = $urandom_range(3);
                it.cx = 16'(it.ax + k * (it.bx - it.ax));
                it.cy = 16'(it.ay + k * (it.by_coord - it.ay));
            end
            1: begin
                it.px = it.bx; it.py = it.by_coord;
            end
            2: begin
                // midpoint of AB
                it.px = 16'((int'(it.ax) + int'(it.bx)) / 2);
                it.py = 16'((int'(it.ay) + int'(it.by_coord)) / 2);
            end
            3: begin
                // centroid, inside for most triangles
                it.px = 16'((int'(it.ax) + int'(it.bx) + int'(it.cx)) / 3);
                it.py = 16'((int'(it.ay) + int'(it.by_coord) + int'(it.cy)) / 3);
            end
            4: begin
                // nearly collinear, huge circumcenter
                it.cx = 16'(it.bx + 1);
                it.cy = 16'(it.by_coord + (it.by_coord - it.ay) / 2);
            end
            default: ;
        endcase
        return it;
    endfunction

    // valid drops only during idle cycles, so back-to-back beats keep it high
    task automatic send_beat(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) send_beat(rand_triangle());
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_item = '0;
        send_idle_pct = 38;
        recv_idle_pct = 78;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, collinear, point on edge/vertex, saturation
        send_beat(mk_item(0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(mk_item(0, 0, 256, 0, 0, 256, 64, 64));
        send_beat(mk_item(0, 0, 256, 0, 0, 256, -64, -64));
        send_beat(mk_item(0, 0, 0, 256, 256, 0, 64, 64));
        send_beat(mk_item(0, 0, 256, 0, 0, 256, 128, 128));
        send_beat(mk_item(0, 0, 256, 0, 0, 256, 256, 0));
        send_beat(mk_item(0, 0, 256, 256, 512, 512, 100, 100));
        send_beat(mk_item(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
        send_beat(mk_item(32767, 32767, -32768, 32767, 32767, -32768, 0, 0));
        send_beat(mk_item(-32768, -32768, 32767, 32767, 32767, -32767, -1, -1));
        send_beat(mk_item(-32768, -32768, 32767, 32767, 32766, 32767, 0, 0));
        send_beat(mk_item(-32768, 0, 32767, 1, 0, 0, 0, 0));
        send_beat(mk_item(-32768, -32768, 32767, 32766, -32767, -32766, 0, 0));
        send_beat(mk_item(32767, -32768, -32768, 32767, 0, 1, 32767, 32767));
        send_beat(mk_item(-1, -1, -1, -1, 5, 5, -32768, 32767));
        send_beat(mk_item(100, 200, 300, -400, -500, 600, 32767, -32768));
        send_beat(mk_item(-32768, 32767, -32768, -32768, 32767, 0, -32767, 0));
        send_beat(mk_item(1, 0, 0, 1, -1, 0, 0, 0));

        run_random(RANDOM_ITEMS / 3);
        send_idle_pct = 78;
        recv_idle_pct = 38;
        run_random(RANDOM_ITEMS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        s_valid <= 0;

        // Drain, then allow the pipeline latency to pass
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && !timed_out) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
